### rtl/dntw_pkg.sv
// Shared types and constants for the dotted-name to wire-format converter.
package dntw_pkg;

    localparam int unsigned LABEL_MAX = 63;
    localparam int unsigned NAME_MAX  = 255;
    localparam int unsigned LABEL_AW  = 6;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;

    localparam logic MODE_TEXT   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_LABEL_LONG = 2'd1,
        ST_NAME_LONG  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_BSL  = 2'd1,
        ESC_OCT1 = 2'd2,
        ESC_OCT2 = 2'd3
    } t_esc;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_REPLAY = 2'd1,
        S_DRAIN  = 2'd2,
        S_ERR    = 2'd3
    } t_state;

endpackage

### rtl/dntw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module dntw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 63
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/dns_name_text_to_wire_unit.sv
// Top level of the converter from dotted DNS name text to DNS wire format.
//
//  Channel  | Direction | Signals                        | Contents
//  ---------+-----------+--------------------------------+------------------------------------
//  s_axis   | in        | tvalid tready tdata tuser      | one text byte or a finish command
//  m_axis   | out       | tvalid tready tdata tlast tuser| up to two wire bytes and a status
//
// When a non-octal byte or a finish ends an octal escape of one or two
// digits, the collected value is stored first and the item is then replayed
// from the replay registers. A dot that closes a label of n bytes then streams
// n + 1 wire bytes out of the label memory at one byte per cycle while the
// output is not stalled, set by its single read port; a finish adds the zero
// byte. The reset is synchronous and clears all control state; the label
// memory needs no clearing since each entry is written before it is read. A
// stalled output holds the drain at the next pair of bytes, while a text byte
// that yields no result is still taken with a result waiting.
module dns_name_text_to_wire_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input transaction.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] mode
    // Output transaction.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] first_byte, [15:8] second_byte,
                                        // [16] second_valid, [23:17] zero
    output logic        m_axis_tlast,   // run_last
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    // Control state.
    dntw_pkg::t_state  r_state, n_state;
    dntw_pkg::t_esc    r_esc, n_esc;
    dntw_pkg::t_status r_fail, n_fail;
    logic [5:0]        r_label_count, n_label_count;
    logic [7:0]        r_name_count, n_name_count;
    logic [7:0]        r_esc_value, n_esc_value;
    logic              r_half, n_half;
    logic              r_out_valid, n_out_valid;

    // Payload registers.
    logic              r_rep_mode, n_rep_mode;
    logic [7:0]        r_rep_byte, n_rep_byte;
    logic [5:0]        r_len, n_len;
    logic              r_fin, n_fin;
    logic [6:0]        r_k, n_k;
    logic [6:0]        r_end, n_end;
    logic [7:0]        r_hold, n_hold;
    logic [7:0]        r_out_first, n_out_first;
    logic [7:0]        r_out_second, n_out_second;
    logic              r_out_sv, n_out_sv;
    logic              r_out_last, n_out_last;
    logic [1:0]        r_out_status, n_out_status;

    // Label memory.
    logic       ram_we;
    logic [5:0] ram_waddr;
    logic [7:0] ram_wdata;
    logic [5:0] ram_raddr;
    logic [7:0] ram_rdata;

    dntw_ram #(
        .WIDTH (8),
        .DEPTH (dntw_pkg::LABEL_MAX)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Item decode and drain signals.
    logic       do_item;
    logic       item_mode;
    logic [7:0] item_byte;
    logic       item_octal;
    logic [7:0] oct_value;
    logic       add_req;
    logic [7:0] add_val;
    logic       close_req;
    logic       fin_req;
    logic [8:0] sum_label;
    logic [8:0] name_after;
    logic       out_free;
    logic [7:0] cur_byte;
    logic       cur_last;
    logic       drain_done;
    logic [6:0] rd_index;

    assign s_axis_tready = (r_state == dntw_pkg::S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_sv, r_out_second, r_out_first};
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dntw_pkg::S_IDLE;
            r_esc         <= dntw_pkg::ESC_NONE;
            r_fail        <= dntw_pkg::ST_OK;
            r_label_count <= '0;
            r_name_count  <= '0;
            r_esc_value   <= '0;
            r_half        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_esc         <= n_esc;
            r_fail        <= n_fail;
            r_label_count <= n_label_count;
            r_name_count  <= n_name_count;
            r_esc_value   <= n_esc_value;
            r_half        <= n_half;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rep_mode   <= n_rep_mode;
        r_rep_byte   <= n_rep_byte;
        r_len        <= n_len;
        r_fin        <= n_fin;
        r_k          <= n_k;
        r_end        <= n_end;
        r_hold       <= n_hold;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_sv     <= n_out_sv;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state       = r_state;
        n_esc         = r_esc;
        n_fail        = r_fail;
        n_label_count = r_label_count;
        n_name_count  = r_name_count;
        n_esc_value   = r_esc_value;
        n_half        = r_half;
        n_rep_mode    = r_rep_mode;
        n_rep_byte    = r_rep_byte;
        n_len         = r_len;
        n_fin         = r_fin;
        n_k           = r_k;
        n_end         = r_end;
        n_hold        = r_hold;
        n_out_valid   = r_out_valid;
        n_out_first   = r_out_first;
        n_out_second  = r_out_second;
        n_out_sv      = r_out_sv;
        n_out_last    = r_out_last;
        n_out_status  = r_out_status;

        ram_we    = 1'b0;
        ram_waddr = r_label_count;
        ram_wdata = 8'h00;

        add_req    = 1'b0;
        add_val    = 8'h00;
        close_req  = 1'b0;
        fin_req    = 1'b0;
        drain_done = 1'b0;

        // The output register is free when empty or being taken this cycle.
        out_free = !r_out_valid || m_axis_tready;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        // A replayed item runs through the same decode with no escape pending.
        do_item   = (r_state == dntw_pkg::S_IDLE && s_axis_tvalid)
                    || (r_state == dntw_pkg::S_REPLAY);
        item_mode = (r_state == dntw_pkg::S_REPLAY) ? r_rep_mode : s_axis_tuser;
        item_byte = (r_state == dntw_pkg::S_REPLAY) ? r_rep_byte : s_axis_tdata;
        item_octal = item_byte inside {[dntw_pkg::CH_ZERO:dntw_pkg::CH_SEVEN]};
        oct_value  = {r_esc_value[4:0], item_byte[2:0]};

        sum_label  = {1'b0, r_name_count} + {3'd0, r_label_count} + 9'd1;
        name_after = (r_label_count != 6'd0) ? sum_label : {1'b0, r_name_count};

        if (do_item) begin
            if (r_state == dntw_pkg::S_REPLAY) begin
                n_state = dntw_pkg::S_IDLE;
            end
            if (item_mode == dntw_pkg::MODE_TEXT) begin
                if (r_fail == dntw_pkg::ST_OK) begin
                    case (r_esc)
                        dntw_pkg::ESC_BSL: begin
                            n_esc = dntw_pkg::ESC_NONE;
                            if (item_octal) begin
                                n_esc_value = {5'd0, item_byte[2:0]};
                                n_esc       = dntw_pkg::ESC_OCT1;
                            end else begin
                                add_req = 1'b1;
                                add_val = item_byte;
                            end
                        end
                        dntw_pkg::ESC_OCT1, dntw_pkg::ESC_OCT2: begin
                            if (item_octal) begin
                                n_esc_value = oct_value;
                                if (r_esc == dntw_pkg::ESC_OCT2) begin
                                    n_esc   = dntw_pkg::ESC_NONE;
                                    add_req = 1'b1;
                                    add_val = oct_value;
                                end else begin
                                    n_esc = dntw_pkg::ESC_OCT2;
                                end
                            end else begin
                                // Store the collected value, then handle the byte itself.
                                n_esc      = dntw_pkg::ESC_NONE;
                                add_req    = 1'b1;
                                add_val    = r_esc_value;
                                n_rep_mode = item_mode;
                                n_rep_byte = item_byte;
                                n_state    = dntw_pkg::S_REPLAY;
                            end
                        end
                        default: begin
                            if (item_byte == dntw_pkg::CH_DOT) begin
                                close_req = 1'b1;
                            end else if (item_byte == dntw_pkg::CH_BSL) begin
                                n_esc = dntw_pkg::ESC_BSL;
                            end else begin
                                add_req = 1'b1;
                                add_val = item_byte;
                            end
                        end
                    endcase
                end
            end else begin
                if (r_fail == dntw_pkg::ST_OK
                    && (r_esc == dntw_pkg::ESC_OCT1 || r_esc == dntw_pkg::ESC_OCT2)) begin
                    n_esc      = dntw_pkg::ESC_NONE;
                    add_req    = 1'b1;
                    add_val    = r_esc_value;
                    n_rep_mode = item_mode;
                    n_rep_byte = item_byte;
                    n_state    = dntw_pkg::S_REPLAY;
                end else begin
                    n_esc     = dntw_pkg::ESC_NONE;
                    close_req = 1'b1;
                    fin_req   = 1'b1;
                end
            end
        end

        if (add_req) begin
            if (r_label_count >= 6'(dntw_pkg::LABEL_MAX)) begin
                n_fail = dntw_pkg::ST_LABEL_LONG;
            end else begin
                ram_we        = 1'b1;
                ram_wdata     = add_val;
                n_label_count = r_label_count + 6'd1;
            end
        end

        if (close_req) begin
            if (fin_req) begin
                if (r_fail != dntw_pkg::ST_OK) begin
                    n_state = dntw_pkg::S_ERR;
                end else if (r_label_count != 6'd0
                             && sum_label > 9'(dntw_pkg::NAME_MAX)) begin
                    n_fail  = dntw_pkg::ST_NAME_LONG;
                    n_state = dntw_pkg::S_ERR;
                end else if (name_after + 9'd1 > 9'(dntw_pkg::NAME_MAX)) begin
                    n_fail  = dntw_pkg::ST_NAME_LONG;
                    n_state = dntw_pkg::S_ERR;
                end else begin
                    n_len         = r_label_count;
                    n_fin         = 1'b1;
                    n_k           = (r_label_count == 6'd0) ? 7'd1 : 7'd0;
                    n_end         = {1'b0, r_label_count} + 7'd1;
                    n_half        = 1'b0;
                    n_label_count = '0;
                    n_state       = dntw_pkg::S_DRAIN;
                end
            end else if (r_label_count != 6'd0) begin
                if (sum_label > 9'(dntw_pkg::NAME_MAX)) begin
                    n_fail = dntw_pkg::ST_NAME_LONG;
                end else begin
                    n_name_count  = sum_label[7:0];
                    n_len         = r_label_count;
                    n_fin         = 1'b0;
                    n_k           = 7'd0;
                    n_end         = {1'b0, r_label_count};
                    n_half        = 1'b0;
                    n_label_count = '0;
                    n_state       = dntw_pkg::S_DRAIN;
                end
            end
        end

        // Wire byte at index k: the length, then the label bytes, then the zero byte.
        if (r_k == 7'd0) begin
            cur_byte = {2'd0, r_len};
        end else if (r_k <= {1'b0, r_len}) begin
            cur_byte = ram_rdata;
        end else begin
            cur_byte = 8'h00;
        end
        cur_last = (r_k == r_end);

        if (r_state == dntw_pkg::S_DRAIN) begin
            if (!r_half) begin
                if (cur_last) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_first  = cur_byte;
                        n_out_second = 8'h00;
                        n_out_sv     = 1'b0;
                        n_out_last   = 1'b1;
                        n_out_status = dntw_pkg::ST_OK;
                        drain_done   = 1'b1;
                    end
                end else begin
                    n_hold = cur_byte;
                    n_half = 1'b1;
                    n_k    = r_k + 7'd1;
                end
            end else if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_first  = r_hold;
                n_out_second = cur_byte;
                n_out_sv     = 1'b1;
                n_out_last   = cur_last;
                n_out_status = dntw_pkg::ST_OK;
                n_half       = 1'b0;
                if (cur_last) begin
                    drain_done = 1'b1;
                end else begin
                    n_k = r_k + 7'd1;
                end
            end
            if (drain_done) begin
                n_state = dntw_pkg::S_IDLE;
                if (r_fin) begin
                    n_name_count = '0;
                    n_esc        = dntw_pkg::ESC_NONE;
                    n_esc_value  = '0;
                    n_fail       = dntw_pkg::ST_OK;
                end
            end
        end

        if (r_state == dntw_pkg::S_ERR && out_free) begin
            n_out_valid   = 1'b1;
            n_out_first   = 8'h00;
            n_out_second  = 8'h00;
            n_out_sv      = 1'b0;
            n_out_last    = 1'b1;
            n_out_status  = r_fail;
            n_label_count = '0;
            n_name_count  = '0;
            n_esc         = dntw_pkg::ESC_NONE;
            n_esc_value   = '0;
            n_fail        = dntw_pkg::ST_OK;
            n_state       = dntw_pkg::S_IDLE;
        end

        // Read the label byte that the next cycle will need; a stalled drain
        // keeps the same index, so the same entry is read again.
        rd_index  = n_k - 7'd1;
        ram_raddr = (rd_index < 7'(dntw_pkg::LABEL_MAX)) ? rd_index[5:0] : 6'd0;
    end

    // The drain index never runs past the last wire byte of the run.
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dntw_pkg::S_DRAIN) |-> (r_k <= r_end))
        else $error("drain index past end of run");

    // An error result is a lone, empty, final result.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != dntw_pkg::ST_OK)
        |-> (r_out_last && !r_out_sv && r_out_first == 8'h00))
        else $error("malformed error result");

    // The open label never outgrows the label memory.
    a_label_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_label_count <= 6'(dntw_pkg::LABEL_MAX))
        else $error("label count out of range");

    // Entering the error state requires a recorded failure afterwards.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dntw_pkg::S_ERR) |-> (r_fail != dntw_pkg::ST_OK))
        else $error("error state without failure code");

endmodule
